// ===== hdl/smr_pkg.sv =====
// ----------------------------------------------------------------------------
// smr_pkg: shared types and constants of the spheroid mask rasterizer
// Register indexes, sequencer states, fixed-point widths and the saturating
// product combine used by the rasterizer datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package smr_pkg;

  // Box half-size limit and its width
  localparam logic [7:0] RADIUS_MAX = 8'd127;
  localparam int RAD_W  = 7;
  localparam int CNT_W  = 8;

  // Configuration port
  localparam int CFG_W  = 48;
  localparam int IDX_W  = 3;
  localparam logic [IDX_W-1:0] REG_SPACING      = 3'd0;
  localparam logic [IDX_W-1:0] REG_AXIS         = 3'd1;
  localparam logic [IDX_W-1:0] REG_INV_AXIAL    = 3'd2;
  localparam logic [IDX_W-1:0] REG_INV_PERP     = 3'd3;
  localparam logic [IDX_W-1:0] REG_BOX_RADII    = 3'd4;
  localparam logic [IDX_W-1:0] REG_OUTSIDE_MODE = 3'd5;

  // Datapath widths
  localparam int SP_W    = 16;  // Q8.8 spacing
  localparam int AXV_W   = 16;  // Q1.15 axis component
  localparam int INV_W   = 32;  // inverse square, scaled by 2^32
  localparam int DIFF_W  = 10;  // count minus radius, signed
  localparam int CRD_W   = 25;  // coordinate, signed Q.8 mm
  localparam int MUL_W   = 33;  // shared multiplier operand, signed
  localparam int PROD_W  = 2 * MUL_W;
  localparam int LEN_W   = 48;  // squared length, Q.16
  localparam int DOT_W   = 41;  // axial dot, signed Q.23
  localparam int MAG_W   = 26;  // rounded axial magnitude, Q.8
  localparam int AX2_W   = 51;  // axial squared, Q.16
  localparam int LO_W    = 64;  // low partial product
  localparam int HI_W    = 52;  // high partial product
  localparam int TERM_W  = 50;  // saturated term, Q.48
  localparam int SUM_W   = TERM_W + 1;

  localparam logic [TERM_W-1:0] TERM_SAT     = {1'b1, {(TERM_W-1){1'b0}}};
  localparam logic [SUM_W-1:0]  INSIDE_LIMIT = {3'b001, {(SUM_W-3){1'b0}}};
  localparam logic [DOT_W:0]    ROUND_HALF   = {{(DOT_W-14){1'b0}}, 1'b1, 14'd0};

  localparam logic signed [1:0] MASK_IN       = 2'sb01;
  localparam logic signed [1:0] MASK_OUT_NEG  = 2'sb11;
  localparam logic signed [1:0] MASK_OUT_ZERO = 2'sb00;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COORD,
    ST_SQ,
    ST_DOT,
    ST_ACC,
    ST_ROUND,
    ST_MAGSQ,
    ST_PA_LO,
    ST_PA_HI,
    ST_PP_LO,
    ST_PP_HI,
    ST_PP_FIN,
    ST_EMIT
  } state_t;

  // Clamp a box half size to RADIUS_MAX
  function automatic logic [RAD_W-1:0] sat_radius(input logic [7:0] f);
    sat_radius = (f > RADIUS_MAX) ? RADIUS_MAX[RAD_W-1:0] : f[RAD_W-1:0];
  endfunction

  // Join high and low partial products of a 51x32 product, saturate at 2^49
  function automatic logic [TERM_W-1:0] sat_combine(input logic [HI_W-1:0] hi,
                                                    input logic [LO_W-1:0] lo);
    logic [HI_W:0] hi_sum;
    hi_sum = {1'b0, hi} + {{(HI_W-31){1'b0}}, lo[63:32]};
    if (hi_sum[HI_W:17] != '0) begin
      sat_combine = TERM_SAT;
    end else begin
      sat_combine = {1'b0, hi_sum[16:0], lo[31:0]};
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/smr_mul.sv =====
// ----------------------------------------------------------------------------
// smr_mul: shared signed multiplier of the rasterizer
// One 33x33 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module smr_mul (
  input  wire logic                               clk,
  input  wire logic signed [smr_pkg::MUL_W-1:0]   a_i,
  input  wire logic signed [smr_pkg::MUL_W-1:0]   b_i,
  output logic signed [smr_pkg::PROD_W-1:0]       p_o
);

  logic signed [smr_pkg::PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a_i * b_i;
  end

  assign p_o = p_r;

endmodule

`default_nettype wire

// ===== hdl/spheroid_mask_raster.sv =====
// ----------------------------------------------------------------------------
// spheroid_mask_raster: voxel mask rasterizer for a rotated spheroid
// Walks a (2rx+1)x(2ry+1)x(2rz+1) box in x-fastest order and tells for each
// voxel whether it lies inside axial^2/a^2 + perp^2/b^2 <= 1.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_restart): each transaction asks
//    for the next voxel; in_restart=1 starts over at voxel (0,0,0).
//  - Result channel (out_valid / out_stall / out_*): one transaction per input
//    transaction with the mask value, voxel indexes and a last-voxel flag.
//  - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//    ready; write only while the block is idle.
//  - Sequencing: one shared 33x33 multiplier does every product in turn. Each
//    voxel runs a coordinate, square and dot product pass for x; the first
//    voxel of a row adds one such pass for y, and the first voxel of a slice
//    adds one for z and one for y. in_stall is high for the whole
//    computation, so the next input waits until the result is loaded.
//  - A finished result sits in the output register; the next input is
//    accepted meanwhile. If the receiver stalls, the sequencer holds its
//    last step until the output register frees up.
//  - Reset (rst_n low, synchronous) loads the default configuration and puts
//    the raster at the first voxel with no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module spheroid_mask_raster (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_restart,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [1:0]                       out_mask_value,
  output logic [smr_pkg::CNT_W-1:0]               out_voxel_x,
  output logic [smr_pkg::CNT_W-1:0]               out_voxel_y,
  output logic [smr_pkg::CNT_W-1:0]               out_voxel_z,
  output logic                                    out_last_voxel,
  // configuration channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [smr_pkg::IDX_W-1:0]          cfg_index,
  input  wire logic [smr_pkg::CFG_W-1:0]          cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [47:0]                  spacing_r;
  logic [47:0]                  axis_r;
  logic [smr_pkg::INV_W-1:0]    inv_ax_r;
  logic [smr_pkg::INV_W-1:0]    inv_pp_r;
  logic [23:0]                  radii_r;
  logic                         omo_r;

  // Sequencer and raster position
  smr_pkg::state_t              state_r, state_nxt;
  smr_pkg::axis_sel_t           ax_r;
  logic [smr_pkg::CNT_W-1:0]    col_r, row_r, sl_r;
  logic                         out_valid_r;

  // Datapath registers
  logic signed [smr_pkg::CRD_W-1:0] coord_r;
  logic [smr_pkg::LEN_W-1:0]        slice_len_r, row_len_r, len_r;
  logic signed [smr_pkg::DOT_W-1:0] slice_dot_r, row_dot_r, dot_r;
  logic [smr_pkg::MAG_W-1:0]        mag_r;
  logic [smr_pkg::AX2_W-1:0]        ax2_r;
  logic [smr_pkg::LEN_W-1:0]        perp_r;
  logic [smr_pkg::LO_W-1:0]         lo_r;
  logic [smr_pkg::TERM_W-1:0]       term_a_r, term_b_r;

  logic signed [1:0]            mask_r;
  logic [smr_pkg::CNT_W-1:0]    vx_r, vy_r, vz_r;
  logic                         last_r;

  // Shared multiplier
  logic signed [smr_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [smr_pkg::PROD_W-1:0] prod;

  smr_mul u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (prod)
  );

  // --------------------------------------------------------------------------
  // Box geometry
  // --------------------------------------------------------------------------
  logic [smr_pkg::RAD_W-1:0]  rad_x, rad_y, rad_z;
  logic [smr_pkg::CNT_W-1:0]  end_x, end_y, end_z;
  logic                       out_of_box, clr_pos;
  logic [smr_pkg::CNT_W-1:0]  col_e, row_e;

  assign rad_x = smr_pkg::sat_radius(radii_r[7:0]);
  assign rad_y = smr_pkg::sat_radius(radii_r[15:8]);
  assign rad_z = smr_pkg::sat_radius(radii_r[23:16]);
  assign end_x = {rad_x, 1'b0};
  assign end_y = {rad_y, 1'b0};
  assign end_z = {rad_z, 1'b0};

  assign out_of_box = (col_r > end_x) || (row_r > end_y) || (sl_r > end_z);
  assign clr_pos    = in_restart || out_of_box;
  assign col_e      = clr_pos ? '0 : col_r;
  assign row_e      = clr_pos ? '0 : row_r;

  // Per-axis operand selection
  logic [smr_pkg::CNT_W-1:0]         cnt_sel;
  logic [smr_pkg::RAD_W-1:0]         rad_sel;
  logic [smr_pkg::SP_W-1:0]          sp_sel;
  logic [smr_pkg::AXV_W-1:0]         axv_sel;
  logic signed [smr_pkg::DIFF_W-1:0] diff;

  always_comb begin
    case (ax_r)
      smr_pkg::AX_X: begin
        cnt_sel = col_r;
        rad_sel = rad_x;
        sp_sel  = spacing_r[15:0];
        axv_sel = axis_r[15:0];
      end
      smr_pkg::AX_Y: begin
        cnt_sel = row_r;
        rad_sel = rad_y;
        sp_sel  = spacing_r[31:16];
        axv_sel = axis_r[31:16];
      end
      smr_pkg::AX_Z: begin
        cnt_sel = sl_r;
        rad_sel = rad_z;
        sp_sel  = spacing_r[47:32];
        axv_sel = axis_r[47:32];
      end
      default: begin
        cnt_sel = col_r;
        rad_sel = rad_x;
        sp_sel  = spacing_r[15:0];
        axv_sel = axis_r[15:0];
      end
    endcase
  end

  assign diff = signed'({2'b00, cnt_sel}) - signed'({3'b000, rad_sel});

  // Rounding of the axial dot to Q.8 and the perpendicular part
  logic [smr_pkg::DOT_W-1:0]  dot_abs;
  logic [smr_pkg::DOT_W:0]    dot_rnd;
  logic [smr_pkg::AX2_W-1:0]  ax2_now;
  logic [smr_pkg::LEN_W-1:0]  perp_now;

  assign dot_abs = dot_r[smr_pkg::DOT_W-1] ? 41'(-dot_r) : 41'(dot_r);
  assign dot_rnd = {1'b0, dot_abs} + smr_pkg::ROUND_HALF;
  assign ax2_now = prod[smr_pkg::AX2_W-1:0];
  assign perp_now = ({3'b000, len_r} > ax2_now) ? (len_r - ax2_now[smr_pkg::LEN_W-1:0]) : '0;

  // Final sum and inside test
  logic [smr_pkg::SUM_W-1:0] total;
  logic                      in_shape;
  logic                      emit_ok;

  assign total    = {1'b0, term_a_r} + {1'b0, term_b_r};
  assign in_shape = (total <= smr_pkg::INSIDE_LIMIT);
  assign emit_ok  = !out_valid_r || !out_stall;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smr_pkg::ST_IDLE:   if (in_valid) state_nxt = smr_pkg::ST_COORD;
      smr_pkg::ST_COORD:  state_nxt = smr_pkg::ST_SQ;
      smr_pkg::ST_SQ:     state_nxt = smr_pkg::ST_DOT;
      smr_pkg::ST_DOT:    state_nxt = smr_pkg::ST_ACC;
      smr_pkg::ST_ACC: begin
        state_nxt = (ax_r == smr_pkg::AX_X) ? smr_pkg::ST_ROUND : smr_pkg::ST_COORD;
      end
      smr_pkg::ST_ROUND:  state_nxt = smr_pkg::ST_MAGSQ;
      smr_pkg::ST_MAGSQ:  state_nxt = smr_pkg::ST_PA_LO;
      smr_pkg::ST_PA_LO:  state_nxt = smr_pkg::ST_PA_HI;
      smr_pkg::ST_PA_HI:  state_nxt = smr_pkg::ST_PP_LO;
      smr_pkg::ST_PP_LO:  state_nxt = smr_pkg::ST_PP_HI;
      smr_pkg::ST_PP_HI:  state_nxt = smr_pkg::ST_PP_FIN;
      smr_pkg::ST_PP_FIN: state_nxt = smr_pkg::ST_EMIT;
      smr_pkg::ST_EMIT:   if (emit_ok) state_nxt = smr_pkg::ST_IDLE;
      default:            state_nxt = smr_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs (multiplier operands, handshakes)
  // --------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      smr_pkg::ST_COORD: begin
        // coordinate = (count - radius) * spacing
        mul_a = {{(smr_pkg::MUL_W-smr_pkg::DIFF_W){diff[smr_pkg::DIFF_W-1]}}, diff};
        mul_b = {{(smr_pkg::MUL_W-smr_pkg::SP_W){1'b0}}, sp_sel};
      end
      smr_pkg::ST_SQ: begin
        mul_a = prod[smr_pkg::MUL_W-1:0];
        mul_b = prod[smr_pkg::MUL_W-1:0];
      end
      smr_pkg::ST_DOT: begin
        mul_a = {{(smr_pkg::MUL_W-smr_pkg::CRD_W){coord_r[smr_pkg::CRD_W-1]}}, coord_r};
        mul_b = {{(smr_pkg::MUL_W-smr_pkg::AXV_W){axv_sel[smr_pkg::AXV_W-1]}}, axv_sel};
      end
      smr_pkg::ST_MAGSQ: begin
        mul_a = {{(smr_pkg::MUL_W-smr_pkg::MAG_W){1'b0}}, mag_r};
        mul_b = {{(smr_pkg::MUL_W-smr_pkg::MAG_W){1'b0}}, mag_r};
      end
      smr_pkg::ST_PA_LO: begin
        mul_a = {1'b0, ax2_now[31:0]};
        mul_b = {1'b0, inv_ax_r};
      end
      smr_pkg::ST_PA_HI: begin
        mul_a = {{(smr_pkg::MUL_W-19){1'b0}}, ax2_r[smr_pkg::AX2_W-1:32]};
        mul_b = {1'b0, inv_ax_r};
      end
      smr_pkg::ST_PP_LO: begin
        mul_a = {1'b0, perp_r[31:0]};
        mul_b = {1'b0, inv_pp_r};
      end
      smr_pkg::ST_PP_HI: begin
        mul_a = {{(smr_pkg::MUL_W-16){1'b0}}, perp_r[smr_pkg::LEN_W-1:32]};
        mul_b = {1'b0, inv_pp_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign in_stall  = (state_r != smr_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Control registers: configuration, sequencer, raster position
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r   <= 48'd1103823372544;
      axis_r      <= 48'd32767;
      inv_ax_r    <= 32'd16777216;
      inv_pp_r    <= 32'd16777216;
      radii_r     <= 24'd460551;
      omo_r       <= 1'b1;
      state_r     <= smr_pkg::ST_IDLE;
      ax_r        <= smr_pkg::AX_X;
      col_r       <= '0;
      row_r       <= '0;
      sl_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          smr_pkg::REG_SPACING:      spacing_r <= cfg_data;
          smr_pkg::REG_AXIS:         axis_r    <= cfg_data;
          smr_pkg::REG_INV_AXIAL:    inv_ax_r  <= cfg_data[smr_pkg::INV_W-1:0];
          smr_pkg::REG_INV_PERP:     inv_pp_r  <= cfg_data[smr_pkg::INV_W-1:0];
          smr_pkg::REG_BOX_RADII:    radii_r   <= cfg_data[23:0];
          smr_pkg::REG_OUTSIDE_MODE: omo_r     <= cfg_data[0];
          default: ;
        endcase
      end

      // load a fresh result, or drop the old one once the receiver takes it
      if (state_r == smr_pkg::ST_EMIT && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        smr_pkg::ST_IDLE: begin
          if (in_valid) begin
            // restart or stale position: go back to the first voxel
            if (clr_pos) begin
              col_r <= '0;
              row_r <= '0;
              sl_r  <= '0;
            end
            // start at the outermost part that needs a fresh latch
            if (col_e == '0 && row_e == '0) begin
              ax_r <= smr_pkg::AX_Z;
            end else if (col_e == '0) begin
              ax_r <= smr_pkg::AX_Y;
            end else begin
              ax_r <= smr_pkg::AX_X;
            end
          end
        end
        smr_pkg::ST_ACC: begin
          if (ax_r == smr_pkg::AX_Z) begin
            ax_r <= smr_pkg::AX_Y;
          end else if (ax_r == smr_pkg::AX_Y) begin
            ax_r <= smr_pkg::AX_X;
          end
        end
        smr_pkg::ST_EMIT: begin
          if (emit_ok) begin
            // advance the raster, x fastest
            if (col_r == end_x) begin
              col_r <= '0;
              if (row_r == end_y) begin
                row_r <= '0;
                sl_r  <= (sl_r == end_z) ? '0 : sl_r + 8'd1;
              end else begin
                row_r <= row_r + 8'd1;
              end
            end else begin
              col_r <= col_r + 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      smr_pkg::ST_SQ: begin
        coord_r <= prod[smr_pkg::CRD_W-1:0];
      end
      smr_pkg::ST_DOT: begin
        // squared coordinate is in the product register
        case (ax_r)
          smr_pkg::AX_Z: slice_len_r <= prod[smr_pkg::LEN_W-1:0];
          smr_pkg::AX_Y: row_len_r   <= slice_len_r + prod[smr_pkg::LEN_W-1:0];
          default:       len_r       <= row_len_r + prod[smr_pkg::LEN_W-1:0];
        endcase
      end
      smr_pkg::ST_ACC: begin
        case (ax_r)
          smr_pkg::AX_Z: slice_dot_r <= prod[smr_pkg::DOT_W-1:0];
          smr_pkg::AX_Y: row_dot_r   <= slice_dot_r + signed'(prod[smr_pkg::DOT_W-1:0]);
          default:       dot_r       <= row_dot_r + signed'(prod[smr_pkg::DOT_W-1:0]);
        endcase
      end
      smr_pkg::ST_ROUND: begin
        mag_r <= dot_rnd[smr_pkg::DOT_W-1:15];
      end
      smr_pkg::ST_PA_LO: begin
        ax2_r  <= ax2_now;
        perp_r <= perp_now;
      end
      smr_pkg::ST_PA_HI: begin
        lo_r <= prod[smr_pkg::LO_W-1:0];
      end
      smr_pkg::ST_PP_LO: begin
        term_a_r <= smr_pkg::sat_combine(prod[smr_pkg::HI_W-1:0], lo_r);
      end
      smr_pkg::ST_PP_HI: begin
        lo_r <= prod[smr_pkg::LO_W-1:0];
      end
      smr_pkg::ST_PP_FIN: begin
        term_b_r <= smr_pkg::sat_combine(prod[smr_pkg::HI_W-1:0], lo_r);
      end
      smr_pkg::ST_EMIT: begin
        if (emit_ok) begin
          if (in_shape) begin
            mask_r <= smr_pkg::MASK_IN;
          end else begin
            mask_r <= omo_r ? smr_pkg::MASK_OUT_NEG : smr_pkg::MASK_OUT_ZERO;
          end
          vx_r   <= col_r;
          vy_r   <= row_r;
          vz_r   <= sl_r;
          last_r <= (col_r == end_x) && (row_r == end_y) && (sl_r == end_z);
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_mask_value = mask_r;
  assign out_voxel_x    = vx_r;
  assign out_voxel_y    = vy_r;
  assign out_voxel_z    = vz_r;
  assign out_last_voxel = last_r;

endmodule

`default_nettype wire
